// File: design/iso_pkg.sv
package iso_pkg;

    // Position within the timestamp text: one member per expected character
    typedef enum logic [4:0] {
        PH_YEAR0,
        PH_YEAR1,
        PH_YEAR2,
        PH_YEAR3,
        PH_DASH1,
        PH_MON0,
        PH_MON1,
        PH_DASH2,
        PH_DAY0,
        PH_DAY1,
        PH_SEP,
        PH_HOUR0,
        PH_HOUR1,
        PH_COLON1,
        PH_MIN0,
        PH_MIN1,
        PH_COLON2,
        PH_SEC0,
        PH_SEC1,
        PH_TAIL,
        PH_FRAC,
        PH_OFFH0,
        PH_OFFH1,
        PH_OFFCOLON,
        PH_OFFM0,
        PH_OFFM1,
        PH_DONE
    } phase_t;

    localparam logic [1:0] OFF_NONE  = 2'd0;
    localparam logic [1:0] OFF_PLUS  = 2'd1;
    localparam logic [1:0] OFF_MINUS = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_T  = 8'h54;
    localparam logic [7:0] CH_LC_T  = 8'h74;

    // Parsed fields of one complete string, handed to the converter
    typedef struct packed {
        logic        good;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [1:0]  off_sign;
        logic [6:0]  off_hours;
        logic [6:0]  off_minutes;
    } stamp_t;

    // Day of year at which each month starts, non-leap year
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] r;
        begin
            unique case (mon)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd59;
                4'd3:    r = 9'd90;
                4'd4:    r = 9'd120;
                4'd5:    r = 9'd151;
                4'd6:    r = 9'd181;
                4'd7:    r = 9'd212;
                4'd8:    r = 9'd243;
                4'd9:    r = 9'd273;
                4'd10:   r = 9'd304;
                4'd11:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: design/iso8601_timestamp_parser.sv
// A result passes stage registers A to E and the output register after the last character.
// Throughput: one character per cycle unless a last character waits for room; the character
// parser updates its accumulators per character; the epoch conversion is a six-register pipeline.
// A stalled result only blocks input once every pipeline register holds a string.
// Reset (rst_n, asynchronous, active low) clears the parser state and all valid flags.
module iso8601_timestamp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  logic [7:0]         ch,
    input  logic               has_char,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               ok,
    output logic signed [35:0] epoch_seconds
);
    import iso_pkg::*;

    // Parser state: position in the text, sticky failure flag and the field accumulators
    phase_t      phase_reg, phase_next;
    logic        failed_reg, failed_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [1:0]  off_sign_reg, off_sign_next;
    logic [6:0]  off_hours_reg, off_hours_next;
    logic [6:0]  off_minutes_reg, off_minutes_next;

    logic        accept;
    logic        stamp_valid, stamp_ready;
    stamp_t      stamp;
    logic        is_digit;
    logic [3:0]  digit;
    logic        step;

    // Shift one decimal digit into an accumulator
    function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
        return 7'((acc << 3) + (acc << 1) + {3'b0, d});
    endfunction

    function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
        return 14'((acc << 3) + (acc << 1) + {10'b0, d});
    endfunction

    // Only a last character needs room in the converter; others never stall
    assign char_ready  = stamp_ready || !last;
    assign accept      = char_valid && char_ready;
    assign stamp_valid = char_valid && last;

    assign is_digit = ch >= CH_ZERO && ch <= CH_NINE;
    assign digit    = ch[3:0];

    always_comb
    begin
        phase_next       = phase_reg;
        failed_next      = failed_reg;
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        off_sign_next    = off_sign_reg;
        off_hours_next   = off_hours_reg;
        off_minutes_next = off_minutes_reg;
        step             = 1'b0;

        if (has_char && !failed_reg)
        begin
            unique case (phase_reg)
                PH_YEAR0, PH_YEAR1, PH_YEAR2, PH_YEAR3:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        year_next = push14(year_reg, digit);
                        step      = 1'b1;
                    end
                end
                PH_MON0, PH_MON1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        month_next = push7(month_reg, digit);
                        step       = 1'b1;
                    end
                end
                PH_DAY0, PH_DAY1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        day_next = push7(day_reg, digit);
                        step     = 1'b1;
                    end
                end
                PH_HOUR0, PH_HOUR1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        hour_next = push7(hour_reg, digit);
                        step      = 1'b1;
                    end
                end
                PH_MIN0, PH_MIN1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        minute_next = push7(minute_reg, digit);
                        step        = 1'b1;
                    end
                end
                PH_SEC0, PH_SEC1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        second_next = push7(second_reg, digit);
                        step        = 1'b1;
                    end
                end
                PH_OFFH0, PH_OFFH1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        off_hours_next = push7(off_hours_reg, digit);
                        step           = 1'b1;
                    end
                end
                PH_OFFM0, PH_OFFM1:
                begin
                    if (!is_digit) failed_next = 1'b1;
                    else
                    begin
                        off_minutes_next = push7(off_minutes_reg, digit);
                        step             = 1'b1;
                    end
                end
                PH_DASH1, PH_DASH2:
                begin
                    if (ch != CH_DASH) failed_next = 1'b1;
                    else step = 1'b1;
                end
                PH_SEP:
                begin
                    if (ch != CH_UC_T && ch != CH_LC_T && ch != CH_SPACE) failed_next = 1'b1;
                    else step = 1'b1;
                end
                PH_COLON1, PH_COLON2, PH_OFFCOLON:
                begin
                    if (ch != CH_COLON) failed_next = 1'b1;
                    else step = 1'b1;
                end
                PH_TAIL, PH_FRAC:
                begin
                    // fraction digits are skipped; a second dot ends parsing
                    if (phase_reg == PH_TAIL && ch == CH_DOT)
                        phase_next = PH_FRAC;
                    else if (phase_reg == PH_FRAC && is_digit)
                        phase_next = PH_FRAC;
                    else if (ch == CH_PLUS)
                    begin
                        off_sign_next = OFF_PLUS;
                        phase_next    = PH_OFFH0;
                    end
                    else if (ch == CH_DASH)
                    begin
                        off_sign_next = OFF_MINUS;
                        phase_next    = PH_OFFH0;
                    end
                    else
                        phase_next = PH_DONE;
                end
                PH_DONE:
                begin
                    // trailing text is ignored
                end
                default:
                    failed_next = 1'b1;
            endcase
        end

        if (step)
            phase_next = phase_t'(phase_reg + 5'd1);

        stamp.good        = !failed_next && (phase_next == PH_TAIL || phase_next == PH_FRAC
                                             || phase_next == PH_DONE);
        stamp.year        = year_next;
        stamp.month       = month_next;
        stamp.day         = day_next;
        stamp.hour        = hour_next;
        stamp.minute      = minute_next;
        stamp.second      = second_next;
        stamp.off_sign    = off_sign_next;
        stamp.off_hours   = off_hours_next;
        stamp.off_minutes = off_minutes_next;

        // drop everything once the string is handed over
        if (last)
        begin
            phase_next       = PH_YEAR0;
            failed_next      = 1'b0;
            year_next        = '0;
            month_next       = '0;
            day_next         = '0;
            hour_next        = '0;
            minute_next      = '0;
            second_next      = '0;
            off_sign_next    = OFF_NONE;
            off_hours_next   = '0;
            off_minutes_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_YEAR0;
            failed_reg      <= 1'b0;
            year_reg        <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            off_sign_reg    <= OFF_NONE;
            off_hours_reg   <= '0;
            off_minutes_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            failed_reg      <= failed_next;
            year_reg        <= year_next;
            month_reg       <= month_next;
            day_reg         <= day_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            off_sign_reg    <= off_sign_next;
            off_hours_reg   <= off_hours_next;
            off_minutes_reg <= off_minutes_next;
        end
    end

    // Calendar conversion pipeline with its own result register
    iso_epoch u_epoch (
        .clk           (clk),
        .rst_n         (rst_n),
        .stamp_valid   (stamp_valid),
        .stamp_ready   (stamp_ready),
        .stamp         (stamp),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .ok            (ok),
        .epoch_seconds (epoch_seconds)
    );

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_YEAR0 && !failed_reg && year_reg == 14'd0)
        else $error("parser state not cleared after last character");

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && accept && !last |=> failed_reg)
        else $error("failure flag lost within a string");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && accept && !last |=> phase_reg == PH_DONE)
        else $error("parser left the done position within a string");

endmodule

// File: design/iso_epoch.sv
module iso_epoch (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stamp_valid,
    output logic                 stamp_ready,
    input  iso_pkg::stamp_t      stamp,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 ok,
    output logic signed [35:0]   epoch_seconds
);
    import iso_pkg::*;

    localparam logic signed [39:0] MAX_SECONDS = 40'sd32535215999;

    // stage valids and free flags
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, out_valid_reg;
    logic free_a, free_b, free_c, free_d, free_e, free_out;

    // stage payloads
    stamp_t             a_reg;
    logic signed [14:0] b_y_reg;
    logic [3:0]         b_mon_reg, c_mon_reg;
    logic [6:0]         b_day_reg, c_day_reg;
    logic [18:0]        b_tod_reg, c_tod_reg, d_tod_reg;
    logic [18:0]        b_off_reg, c_off_reg, d_off_reg, e_off_reg;
    logic [1:0]         b_sign_reg, c_sign_reg, d_sign_reg, e_sign_reg;
    logic               b_good_reg, c_good_reg, d_good_reg, e_good_reg;
    logic signed [14:0] c_ydiff_reg;
    logic [11:0]        c_lp_reg;
    logic               c_leap_reg;
    logic signed [23:0] d_days_reg;
    logic signed [39:0] e_t_reg;
    logic               ok_reg;
    logic signed [35:0] epoch_reg;

    assign free_out    = !out_valid_reg || result_ready;
    assign free_e      = !e_valid_reg || free_out;
    assign free_d      = !d_valid_reg || free_e;
    assign free_c      = !c_valid_reg || free_d;
    assign free_b      = !b_valid_reg || free_c;
    assign free_a      = !a_valid_reg || free_b;
    assign stamp_ready = free_a;

    // stage A: normalise month, time of day and offset
    logic [6:0]         a_mon0;
    logic signed [14:0] a_yb;
    logic [14:0]        a_qprod;
    logic [3:0]         a_q;
    logic [6:0]         a_mon_full;
    logic signed [14:0] a_y_next;
    logic [18:0]        a_tod_next, a_off_next;

    always_comb
    begin
        if (a_reg.month == 7'd0)
        begin
            a_mon0 = 7'd11;
            a_yb   = $signed({1'b0, a_reg.year}) - 15'sd1;
        end
        else
        begin
            a_mon0 = a_reg.month - 7'd1;
            a_yb   = $signed({1'b0, a_reg.year});
        end
        a_qprod    = 15'(a_mon0) * 15'd171;
        a_q        = a_qprod[14:11];
        a_mon_full = a_mon0 - 7'({3'b0, a_q} * 7'd12);
        a_y_next   = a_yb + $signed({11'b0, a_q});
        a_tod_next = 19'(a_reg.hour) * 19'd3600 + 19'(a_reg.minute) * 19'd60
                   + 19'(a_reg.second);
        a_off_next = 19'(a_reg.off_hours) * 19'd3600 + 19'(a_reg.off_minutes) * 19'd60;
    end

    // stage B: year range, leap days before the year, leap flag
    logic        b_in_range;
    logic [13:0] b_yu, b_ym1;
    logic [26:0] b_prod_m1, b_prod_y;
    logic [7:0]  b_q100_m1, b_q100_y;
    logic        b_mod100_zero, b_leap_next;
    logic [11:0] b_lp_next;
    logic signed [14:0] b_ydiff_next;

    always_comb
    begin
        b_in_range    = b_y_reg >= 15'sd1969;
        b_yu          = b_y_reg[13:0];
        b_ym1         = b_yu - 14'd1;
        b_prod_m1     = 27'(b_ym1) * 27'd5243;
        b_prod_y      = 27'(b_yu) * 27'd5243;
        b_q100_m1     = b_prod_m1[26:19];
        b_q100_y      = b_prod_y[26:19];
        b_lp_next     = 12'(b_ym1 >> 2) - 12'(b_q100_m1) + 12'(b_q100_m1 >> 2);
        b_mod100_zero = b_yu == 14'({6'b0, b_q100_y} * 14'd100);
        b_leap_next   = (b_yu[1:0] == 2'd0 && !b_mod100_zero)
                     || (b_mod100_zero && b_q100_y[1:0] == 2'd0);
        b_ydiff_next  = b_y_reg - 15'sd1970;
    end

    // stage C: day count since the epoch
    logic signed [23:0] c_days_next;
    logic               c_leap_add;

    always_comb
    begin
        c_leap_add  = c_mon_reg >= 4'd2 && c_leap_reg;
        c_days_next = 24'(c_ydiff_reg) * 24'sd365 + $signed({12'b0, c_lp_reg}) - 24'sd477
                    + $signed({15'b0, month_start(c_mon_reg)})
                    + $signed({23'b0, c_leap_add})
                    + $signed({17'b0, c_day_reg}) - 24'sd1;
    end

    // stage D: seconds
    logic signed [39:0] d_t_next;
    assign d_t_next = 40'(d_days_reg) * 40'sd86400 + $signed({21'b0, d_tod_reg});

    // stage E: span check and offset
    logic               e_ok_next;
    logic signed [39:0] e_res;
    logic signed [39:0] e_off_s;

    always_comb
    begin
        e_off_s   = $signed({21'b0, e_off_reg});
        e_ok_next = e_good_reg && e_t_reg >= 40'sd0 && e_t_reg <= MAX_SECONDS;
        if (e_sign_reg == OFF_NONE)
            e_res = e_t_reg;
        else if (e_sign_reg == OFF_PLUS)
            e_res = e_t_reg - e_off_s;
        else
            e_res = e_t_reg + e_off_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free_a)   a_valid_reg   <= stamp_valid;
            if (free_b)   b_valid_reg   <= a_valid_reg;
            if (free_c)   c_valid_reg   <= b_valid_reg;
            if (free_d)   d_valid_reg   <= c_valid_reg;
            if (free_e)   e_valid_reg   <= d_valid_reg;
            if (free_out) out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_a && stamp_valid)
            a_reg <= stamp;
        if (free_b && a_valid_reg)
        begin
            b_y_reg    <= a_y_next;
            b_mon_reg  <= a_mon_full[3:0];
            b_day_reg  <= a_reg.day;
            b_tod_reg  <= a_tod_next;
            b_off_reg  <= a_off_next;
            b_sign_reg <= a_reg.off_sign;
            b_good_reg <= a_reg.good;
        end
        if (free_c && b_valid_reg)
        begin
            c_ydiff_reg <= b_ydiff_next;
            c_lp_reg    <= b_lp_next;
            c_leap_reg  <= b_leap_next;
            c_mon_reg   <= b_mon_reg;
            c_day_reg   <= b_day_reg;
            c_tod_reg   <= b_tod_reg;
            c_off_reg   <= b_off_reg;
            c_sign_reg  <= b_sign_reg;
            c_good_reg  <= b_good_reg && b_in_range;
        end
        if (free_d && c_valid_reg)
        begin
            d_days_reg <= c_days_next;
            d_tod_reg  <= c_tod_reg;
            d_off_reg  <= c_off_reg;
            d_sign_reg <= c_sign_reg;
            d_good_reg <= c_good_reg;
        end
        if (free_e && d_valid_reg)
        begin
            e_t_reg    <= d_t_next;
            e_off_reg  <= d_off_reg;
            e_sign_reg <= d_sign_reg;
            e_good_reg <= d_good_reg;
        end
        if (free_out && e_valid_reg)
        begin
            ok_reg    <= e_ok_next;
            epoch_reg <= e_ok_next ? e_res[35:0] : 36'sd0;
        end
    end

    assign result_valid  = out_valid_reg;
    assign ok            = ok_reg;
    assign epoch_seconds = epoch_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ok |-> epoch_seconds == 36'sd0)
        else $error("failed result carries nonzero seconds");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !stamp_ready |-> a_valid_reg && b_valid_reg && c_valid_reg && d_valid_reg
                         && e_valid_reg && out_valid_reg)
        else $error("stall with a bubble in the pipeline");

    a_month_norm: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_mon_reg < 4'd12)
        else $error("month not normalised");

    a_bad_stays_bad: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && free_out && !e_good_reg |=> !ok)
        else $error("bad stamp reported ok");

endmodule

// File: tb/iso8601_timestamp_parser_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the character-serial ISO 8601 parser. Timestamp text goes in
// one character per transaction. An in-bench predictor keeps its own copy of the parse
// state, and every result transaction is checked against the oldest predicted epoch.
module iso8601_timestamp_parser_tb;
    import iso_pkg::*;

    localparam int         CLK_HALF     = 10;
    localparam int         RESET_CYCLES = 8;
    // Longest legal quiet spell is the long result hold plus a few gaps; allow plenty over
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         LONG_HOLD    = 600;
    // Wait well beyond the result latency after the last character at the end
    localparam int         TAIL_CYCLES  = 20;
    localparam longint     LAST_SECOND  = 64'sd32535215999;
    localparam longint     SECS_PER_DAY = 64'sd86400;
    localparam logic [7:0] CH_UC_Z      = 8'h5a;
    localparam logic [7:0] CH_LC_Z      = 8'h7a;

    typedef logic [7:0] text_t[$];

    typedef struct {
        logic              ok;
        logic signed [35:0] secs;
    } epoch_t;

    logic               clk;
    logic               rst_n;
    logic               char_valid;
    logic               char_ready;
    logic [7:0]         ch;
    logic               has_char;
    logic               last;
    logic               result_valid;
    logic               result_ready;
    logic               ok;
    logic signed [35:0] epoch_seconds;

    // Predictor copy of the parse state
    phase_t      cur_phase;
    logic        cur_failed;
    logic [13:0] cur_year;
    logic [6:0]  cur_month;
    logic [6:0]  cur_day;
    logic [6:0]  cur_hour;
    logic [6:0]  cur_minute;
    logic [6:0]  cur_second;
    logic [1:0]  cur_off_sign;
    logic [6:0]  cur_off_hours;
    logic [6:0]  cur_off_minutes;

    epoch_t expected_stamps[$];

    // Knobs shared between the test tasks and the driving processes
    int char_gap_max   = 0;
    int result_gap_max = 0;
    int marker_pct     = 0;
    bit hold_request   = 1'b0;
    int failures       = 0;
    int idle_cycles    = 0;

    iso8601_timestamp_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .ch           (ch),
        .has_char     (has_char),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ok           (ok),
        .epoch_seconds(epoch_seconds)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_parse_state();
        cur_phase       = PH_YEAR0;
        cur_failed      = 1'b0;
        cur_year        = '0;
        cur_month       = '0;
        cur_day         = '0;
        cur_hour        = '0;
        cur_minute      = '0;
        cur_second      = '0;
        cur_off_sign    = OFF_NONE;
        cur_off_hours   = '0;
        cur_off_minutes = '0;
    endfunction

    // Character seen once the seconds are complete, or the first non-digit of a fraction.
    // Z, z and any other character simply close the string.
    function automatic void end_of_seconds(input logic [7:0] c, input logic dot_ok);
        if (dot_ok && c == CH_DOT)
            cur_phase = PH_FRAC;
        else if (c == CH_UC_Z || c == CH_LC_Z)
            cur_phase = PH_DONE;
        else if (c == CH_PLUS || c == CH_DASH)
        begin
            cur_off_sign = (c == CH_PLUS) ? OFF_PLUS : OFF_MINUS;
            cur_phase    = PH_OFFH0;
        end
        else
            cur_phase = PH_DONE;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic       is_digit;
        logic [3:0] d;
        logic       advance;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        advance  = is_digit;
        // A failed string or a closed one ignores everything up to its end
        if (cur_failed || cur_phase == PH_DONE)
            return;
        case (cur_phase)
            PH_YEAR0, PH_YEAR1, PH_YEAR2, PH_YEAR3:
                if (is_digit) cur_year = 14'(cur_year * 14'd10 + d);
            PH_MON0, PH_MON1:
                if (is_digit) cur_month = 7'(cur_month * 7'd10 + d);
            PH_DAY0, PH_DAY1:
                if (is_digit) cur_day = 7'(cur_day * 7'd10 + d);
            PH_HOUR0, PH_HOUR1:
                if (is_digit) cur_hour = 7'(cur_hour * 7'd10 + d);
            PH_MIN0, PH_MIN1:
                if (is_digit) cur_minute = 7'(cur_minute * 7'd10 + d);
            PH_SEC0, PH_SEC1:
                if (is_digit) cur_second = 7'(cur_second * 7'd10 + d);
            PH_OFFH0, PH_OFFH1:
                if (is_digit) cur_off_hours = 7'(cur_off_hours * 7'd10 + d);
            PH_OFFM0, PH_OFFM1:
                if (is_digit) cur_off_minutes = 7'(cur_off_minutes * 7'd10 + d);
            PH_DASH1, PH_DASH2:
                advance = (c == CH_DASH);
            PH_SEP:
                advance = (c == CH_UC_T) || (c == CH_LC_T) || (c == CH_SPACE);
            PH_COLON1, PH_COLON2, PH_OFFCOLON:
                advance = (c == CH_COLON);
            PH_TAIL:
            begin
                end_of_seconds(c, 1'b1);
                return;
            end
            PH_FRAC:
            begin
                // Skip fraction digits; a second dot only closes the string
                if (!is_digit) end_of_seconds(c, 1'b0);
                return;
            end
            default:
                advance = 1'b0;
        endcase
        if (advance)
            cur_phase = phase_t'(cur_phase + 5'd1);
        else
            cur_failed = 1'b1;
    endfunction

    function automatic longint leaps_upto(input longint y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic longint days_before_month(input longint m);
        case (m)
            0:       return 0;
            1:       return 31;
            2:       return 59;
            3:       return 90;
            4:       return 120;
            5:       return 151;
            6:       return 181;
            7:       return 212;
            8:       return 243;
            9:       return 273;
            10:      return 304;
            default: return 334;
        endcase
    endfunction

    // Normalise the collected fields and turn them into epoch seconds
    function automatic epoch_t close_stamp();
        longint y;
        longint m;
        longint days;
        longint t;
        longint off;
        epoch_t r;
        r.ok   = 1'b0;
        r.secs = '0;
        if (cur_failed)
            return r;
        if (!(cur_phase == PH_TAIL || cur_phase == PH_FRAC || cur_phase == PH_DONE))
            return r;
        y = longint'(cur_year);
        m = longint'(cur_month) - 1;
        // Month zero borrows from the year; large months carry into it
        if (m < 0)
        begin
            m = m + 12;
            y = y - 1;
        end
        y = y + m / 12;
        m = m % 12;
        if (y < 1969)
            return r;
        days = 365 * (y - 1970) + leaps_upto(y - 1) - leaps_upto(1969);
        days = days + days_before_month(m);
        if (m >= 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
            days = days + 1;
        days = days + longint'(cur_day) - 1;
        t = days * SECS_PER_DAY + longint'(cur_hour) * 3600
            + longint'(cur_minute) * 60 + longint'(cur_second);
        if (t < 0 || t > LAST_SECOND)
            return r;
        if (cur_off_sign != OFF_NONE)
        begin
            off = longint'(cur_off_hours) * 3600 + longint'(cur_off_minutes) * 60;
            t   = (cur_off_sign == OFF_PLUS) ? t - off : t + off;
        end
        r.ok   = 1'b1;
        r.secs = t[35:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one character transaction, hold it until taken, then predict from it.
    // Valid is lowered only when a gap follows, so back-to-back items never toggle it.
    task automatic send_char(input logic [7:0] c, input logic has, input logic lst);
        int gap;
        gap = $urandom_range(0, char_gap_max);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        ch         <= c;
        has_char   <= has;
        last       <= lst;
        do @(posedge clk); while (!char_ready);
        if (has)
            parse_char(c);
        if (lst)
        begin
            expected_stamps.insert(expected_stamps.size(), close_stamp());
            clear_parse_state();
        end
    endtask

    // Send a whole string; the end goes on the final character or on a bare end marker.
    // Bare markers without last may be sprinkled in, and must change nothing.
    task automatic send_text(input text_t txt, input bit bare_end);
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 99) < marker_pct)
                send_char(8'($urandom), 1'b0, 1'b0);
            send_char(txt[i], 1'b1, !bare_end && (i == txt.size() - 1));
        end
        if (bare_end || txt.size() == 0)
            send_char(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stop offering, so the last character is not taken again, and wait until
    // every predicted result has been checked
    task automatic wait_for_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (expected_stamps.size() != 0) @(posedge clk);
    endtask

    function automatic text_t bytes_of(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
            q.insert(q.size(), s[i]);
        return q;
    endfunction

    // Mostly well-formed timestamps with random content, some pushed out of range,
    // some with a character trampled, junk appended or the text cut short
    function automatic text_t random_stamp();
        int    year;
        int    pick;
        int    cut;
        string s;
        string sep;
        text_t q;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            year = $urandom_range(0, 9999);
        else if (pick == 1)
        begin
            case ($urandom_range(0, 3))
                0:       year = 1969;
                1:       year = 1970;
                2:       year = 3000;
                default: year = 3001;
            endcase
        end
        else
            year = $urandom_range(1970, 2999);
        case ($urandom_range(0, 2))
            0:       sep = "T";
            1:       sep = "t";
            default: sep = " ";
        endcase
        s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", year,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31),
                      sep,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59));
        if ($urandom_range(0, 2) == 0)
        begin
            s = {s, "."};
            repeat ($urandom_range(0, 8)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            if ($urandom_range(0, 5) == 0)
                s = {s, ".", $sformatf("%0d", $urandom_range(0, 99))};
        end
        case ($urandom_range(0, 5))
            0: ;
            1: s = {s, "Z"};
            2: s = {s, "z"};
            3, 4:
                s = {s, $sformatf("%s%02d:%02d", ($urandom_range(0, 1) == 0) ? "+" : "-",
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 14),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59))};
            default: s = {s, "Q7x"};
        endcase
        q = bytes_of(s);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) q.insert(q.size(), 8'($urandom));
        case ($urandom_range(0, 9))
            0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            1:
            begin
                cut = $urandom_range(0, q.size() - 1);
                while (q.size() > cut) void'(q.pop_back());
            end
            default: ;
        endcase
        return q;
    endfunction

    // Result side: draw a stall after every result transaction, and on request
    // hold off for a long stretch so the pipeline fills and backs up the input
    initial
    begin : result_sink
        int stall;
        stall = 0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        result_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = 0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                if (stall == 0)
                    result_ready <= 1'b1;
            end
            else if (result_valid && result_ready)
            begin
                stall = $urandom_range(0, result_gap_max);
                if (stall > 0)
                    result_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        epoch_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_stamps.size() == 0)
            begin
                $error("unexpected result: ok %0b, epoch_seconds %0d", ok, epoch_seconds);
                failures++;
            end
            else
            begin
                want = expected_stamps.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0b, actual %0b", want.ok, ok);
                    failures++;
                end
                if (epoch_seconds !== want.secs)
                begin
                    $error("epoch_seconds mismatch: expected %0d, actual %0d",
                           want.secs, epoch_seconds);
                    failures++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((char_valid && char_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Accepted forms: separators, fractions, zone letters, offsets, trailing text
    task automatic test_well_formed();
        char_gap_max   = 19;
        result_gap_max = 19;
        send_text(bytes_of("1970-01-01T00:00:00Z"), 1'b0);
        send_text(bytes_of("2024-02-29T12:34:56.789123+05:30"), 1'b0);
        // second dot after the fraction closes the string
        send_text(bytes_of("2000-03-01T00:00:00.5.7Z"), 1'b0);
        send_text(bytes_of("2021-06-15t08:00:00z"), 1'b0);
        send_text(bytes_of("2021-06-15T08:00:00 junk"), 1'b0);
        send_text(bytes_of("2020-01-01T12:30:00.123abc"), 1'b0);
        send_text(bytes_of("2020-01-01 12:30:00.+01:00"), 1'b0);
        // end on a bare marker, with stray markers in the middle
        marker_pct = 30;
        send_text(bytes_of("2020-01-01T12:30:00-02:15"), 1'b1);
        marker_pct = 0;
    endtask

    // Broken strings: bad digits, bad separators, early ends, empty string
    task automatic test_malformed();
        send_text(bytes_of("2020-01-01X00:00:00"), 1'b0);
        send_text(bytes_of("2020-01-0aT00:00:00"), 1'b0);
        send_text(bytes_of("2020-01-01T12:3"), 1'b0);
        send_text(bytes_of("2020-01-01T12:30:00+05:"), 1'b0);
        send_text(bytes_of("2020-01-01T12:30:00+05"), 1'b1);
        send_text(bytes_of("2020-01-01T12:30:00+0a:00"), 1'b0);
        send_text(bytes_of(""), 1'b1);
    endtask

    // Span limits, field extremes and normalisation
    task automatic test_range_limits();
        send_text(bytes_of("3000-12-31T23:59:59"), 1'b0);
        send_text(bytes_of("3000-12-31t23:59:59-99:99"), 1'b0);
        send_text(bytes_of("1970-01-01 00:00:00+99:99"), 1'b0);
        send_text(bytes_of("1970-01-01T00:00:59+00:01"), 1'b0);
        send_text(bytes_of("1969-12-31T23:59:59"), 1'b0);
        send_text(bytes_of("3001-01-01T00:00:00"), 1'b0);
        send_text(bytes_of("2020-00-10T00:00:00"), 1'b0);
        send_text(bytes_of("1999-99-99T99:99:99"), 1'b0);
        send_text(bytes_of("0000-01-01T00:00:00"), 1'b0);
        send_text(bytes_of("9999-12-31T23:59:59"), 1'b0);
    endtask

    // Random strings and byte noise until the character budget is spent;
    // now and then drain every outstanding result before carrying on
    task automatic test_random_stream(input int char_budget, input int send_gap,
                                      input int sink_gap);
        int    sent;
        text_t txt;
        sent           = 0;
        char_gap_max   = send_gap;
        result_gap_max = sink_gap;
        marker_pct     = 4;
        while (sent < char_budget)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                txt = {};
                repeat ($urandom_range(0, 30)) txt.insert(txt.size(), 8'($urandom));
            end
            else
                txt = random_stamp();
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
            send_text(txt, $urandom_range(0, 9) == 0);
            sent += txt.size();
        end
        marker_pct = 0;
    endtask

    // Hold the result side off while strings stream in back to back, then
    // pause the sender until every outstanding result is out
    task automatic test_result_backpressure();
        char_gap_max   = 0;
        result_gap_max = 0;
        hold_request   = 1'b1;
        repeat (12) send_text(random_stamp(), 1'b0);
        wait_for_results();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        ch         <= '0;
        has_char   <= 1'b0;
        last       <= 1'b0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_malformed();
        test_range_limits();
        test_random_stream(180, 19, 19);
        test_random_stream(120, 0, 0);
        test_result_backpressure();
        test_random_stream(120, 0, 19);
        test_random_stream(120, 19, 0);

        // Let the pipeline drain, then allow for any stray result
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
design/iso_pkg.sv
design/iso_epoch.sv
design/iso8601_timestamp_parser.sv
tb/iso8601_timestamp_parser_tb.sv
